[rtl/core/lbm_pkg.sv]
// ----------------------------------------------------------------------------
// lbm_pkg: shared constants, types and fixed-point helpers
// Holds the D2Q9 lattice directions, weights and the rounding product helpers.
// ----------------------------------------------------------------------------
package lbm_pkg;

  localparam int NDIR = 9;
  localparam int QW   = 32;
  localparam int FRAC = 24;
  localparam int OMW  = 26;

  localparam logic [OMW-1:0] OMEGA_RESET = OMW'(26'd16777216);

  localparam logic signed [QW-1:0] Q_ONE       = 32'sd16777216;
  localparam logic signed [QW-1:0] Q_THREE     = 32'sd50331648;
  localparam logic signed [QW-1:0] Q_M_ONEHALF = -32'sd25165824;
  localparam logic signed [QW-1:0] Q_NINE      = 32'sd150994944;
  localparam logic signed [QW-1:0] Q_M_NINE    = -32'sd150994944;

  localparam logic signed [QW-1:0] W_REST = 32'sd7456540;
  localparam logic signed [QW-1:0] W_AXIS = 32'sd1864135;
  localparam logic signed [QW-1:0] W_DIAG = 32'sd466034;

  typedef logic signed [QW-1:0] q_t;
  typedef q_t pop_vec_t [NDIR];

  typedef struct packed {
    logic signed [1:0] cx;
    logic signed [1:0] cy;
  } dir_t;

  function automatic dir_t dir_of(input int k);
    dir_t d;
    d = '{cx: 2'sd0, cy: 2'sd0};
    case (k)
      1: d = '{cx:  2'sd1, cy:  2'sd0};
      2: d = '{cx:  2'sd0, cy:  2'sd1};
      3: d = '{cx: -2'sd1, cy:  2'sd0};
      4: d = '{cx:  2'sd0, cy: -2'sd1};
      5: d = '{cx:  2'sd1, cy:  2'sd1};
      6: d = '{cx: -2'sd1, cy:  2'sd1};
      7: d = '{cx: -2'sd1, cy: -2'sd1};
      8: d = '{cx:  2'sd1, cy: -2'sd1};
      default: d = '{cx: 2'sd0, cy: 2'sd0};
    endcase
    return d;
  endfunction

  function automatic q_t weight_of(input int k);
    q_t w;
    if (k == 0) begin
      w = W_REST;
    end else if (k <= 4) begin
      w = W_AXIS;
    end else begin
      w = W_DIAG;
    end
    return w;
  endfunction

  function automatic q_t sat32(input logic signed [QW+1:0] v);
    q_t r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  // round a 64-bit product to nearest, halves up, then saturate
  function automatic q_t qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic signed [39:0] t;
    q_t r;
    s = p + 64'sd8388608;
    t = s[63:FRAC];
    if (t > 40'sh00_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (t < -40'sh00_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = t[QW-1:0];
    end
    return r;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat32(34'(a) + 34'(b));
  endfunction

endpackage

[rtl/core/lbm_lane.sv]
// ----------------------------------------------------------------------------
// lbm_lane: equilibrium and relaxation of one population direction
// Pipelined core; at most one product level per stage, a new item every cycle.
// ----------------------------------------------------------------------------
module lbm_lane #(
  parameter int DIR = 0
) (
  input  logic                          clk,
  input  logic [lbm_pkg::OMW-1:0]       omega,
  input  lbm_pkg::q_t                   f_in,
  input  lbm_pkg::q_t                   ux_in,
  input  lbm_pkg::q_t                   uy_in,
  input  lbm_pkg::q_t                   uxx_in,
  input  lbm_pkg::q_t                   uyy_in,
  input  lbm_pkg::q_t                   uxy_in,
  input  lbm_pkg::q_t                   rho_in,
  output lbm_pkg::q_t                   new_pop
);

  localparam lbm_pkg::dir_t D = lbm_pkg::dir_of(DIR);
  localparam lbm_pkg::q_t   W = lbm_pkg::weight_of(DIR);
  localparam lbm_pkg::q_t   AX = (D.cx != 0) ? lbm_pkg::Q_THREE : lbm_pkg::Q_M_ONEHALF;
  localparam lbm_pkg::q_t   AY = (D.cy != 0) ? lbm_pkg::Q_THREE : lbm_pkg::Q_M_ONEHALF;
  localparam lbm_pkg::q_t   CXY = (D.cx * D.cy > 0) ? lbm_pkg::Q_NINE :
                                  (D.cx * D.cy < 0) ? lbm_pkg::Q_M_NINE : '0;

  lbm_pkg::q_t cu;
  lbm_pkg::q_t t_cu_r, t_x_r, t_y_r, t_xy_r, wr_r, f1_r;
  lbm_pkg::q_t br_r, wr2_r, f2_r;
  lbm_pkg::q_t feq_r, f3_r;
  lbm_pkg::q_t pa_r, pb_r;
  lbm_pkg::q_t br_nxt;
  logic signed [lbm_pkg::OMW:0] om_s, one_m;

  always_comb begin
    cu = '0;
    if (D.cx > 0) cu = lbm_pkg::qadd(cu, ux_in);
    if (D.cx < 0) cu = lbm_pkg::sat32(34'(cu) - 34'(ux_in));
    if (D.cy > 0) cu = lbm_pkg::qadd(cu, uy_in);
    if (D.cy < 0) cu = lbm_pkg::sat32(34'(cu) - 34'(uy_in));
  end

  always_comb begin
    br_nxt = lbm_pkg::Q_ONE;
    br_nxt = lbm_pkg::qadd(br_nxt, t_cu_r);
    br_nxt = lbm_pkg::qadd(br_nxt, t_x_r);
    br_nxt = lbm_pkg::qadd(br_nxt, t_y_r);
    br_nxt = lbm_pkg::qadd(br_nxt, t_xy_r);
  end

  assign om_s  = $signed({1'b0, omega});
  assign one_m = $signed({1'b0, lbm_pkg::Q_ONE[lbm_pkg::OMW-1:0]}) - om_s;

  always_ff @(posedge clk) begin
    t_cu_r <= lbm_pkg::qround(64'(lbm_pkg::Q_THREE) * 64'(cu));
    t_x_r  <= lbm_pkg::qround(64'(AX) * 64'(uxx_in));
    t_y_r  <= lbm_pkg::qround(64'(AY) * 64'(uyy_in));
    t_xy_r <= lbm_pkg::qround(64'(CXY) * 64'(uxy_in));
    wr_r   <= lbm_pkg::qround(64'(W) * 64'(rho_in));
    f1_r   <= f_in;
    br_r   <= br_nxt;
    wr2_r  <= wr_r;
    f2_r   <= f1_r;
    feq_r  <= lbm_pkg::qround(64'(wr2_r) * 64'(br_r));
    f3_r   <= f2_r;
    pa_r   <= lbm_pkg::qround(64'(f3_r) * 64'(one_m));
    pb_r   <= lbm_pkg::qround(64'(om_s) * 64'(feq_r));
    new_pop <= lbm_pkg::qadd(pa_r, pb_r);
  end

endmodule

[rtl/core/lbm_front.sv]
// ----------------------------------------------------------------------------
// lbm_front: density sum and velocity products shared by all lanes
// Registers the node, its saturated density and ux*ux, uy*uy, ux*uy.
// ----------------------------------------------------------------------------
module lbm_front (
  input  logic                 clk,
  input  lbm_pkg::pop_vec_t    pop,
  input  lbm_pkg::q_t          ux,
  input  lbm_pkg::q_t          uy,
  output lbm_pkg::pop_vec_t    pop_r,
  output lbm_pkg::q_t          ux_r,
  output lbm_pkg::q_t          uy_r,
  output lbm_pkg::q_t          rho_r,
  output lbm_pkg::q_t          uxx_r,
  output lbm_pkg::q_t          uyy_r,
  output lbm_pkg::q_t          uxy_r
);

  logic signed [lbm_pkg::QW+3:0] sum;

  always_comb begin
    sum = '0;
    for (int k = 0; k < lbm_pkg::NDIR; k++) begin
      sum = sum + 36'(pop[k]);
    end
  end

  always_ff @(posedge clk) begin
    pop_r <= pop;
    ux_r  <= ux;
    uy_r  <= uy;
    if (sum > 36'sh0_7FFF_FFFF) begin
      rho_r <= 32'sh7FFF_FFFF;
    end else if (sum < -36'sh0_8000_0000) begin
      rho_r <= 32'sh8000_0000;
    end else begin
      rho_r <= sum[lbm_pkg::QW-1:0];
    end
    uxx_r <= lbm_pkg::qround(64'(ux) * 64'(ux));
    uyy_r <= lbm_pkg::qround(64'(uy) * 64'(uy));
    uxy_r <= lbm_pkg::qround(64'(ux) * 64'(uy));
  end

endmodule

[rtl/core/lattice_d2q9_bgk_collision.sv]
// ----------------------------------------------------------------------------
// lattice_d2q9_bgk_collision: D2Q9 BGK collision of one node per cycle
//
//   channel  ports                        handshake
//   in       in_pop_0..8, in_vel_x/y      start & !busy
//   out      out_new_pop_0..8, density    out_valid, one cycle
//   cfg      cfg_relax_rate               cfg_valid & cfg_ready
//
// One node per cycle; the strobe rises together with the node's result and
// density, which pass the front stage and the lane pipe alongside the valid pipe.
// The depth is set by the front stage plus the lane product chain.
// busy is always low; the receiver cannot stall, so nothing backs up.
// Reset clears the valid pipe and sets omega to 1.0.
// ----------------------------------------------------------------------------
module lattice_d2q9_bgk_collision (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pop_0, in_pop_1, in_pop_2, in_pop_3, in_pop_4,
  input  logic [31:0] in_pop_5, in_pop_6, in_pop_7, in_pop_8,
  input  logic [31:0] in_vel_x, in_vel_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [25:0] cfg_relax_rate,
  output logic        out_valid,
  output logic [31:0] out_new_pop_0, out_new_pop_1, out_new_pop_2, out_new_pop_3,
  output logic [31:0] out_new_pop_4, out_new_pop_5, out_new_pop_6, out_new_pop_7,
  output logic [31:0] out_new_pop_8,
  output logic [31:0] out_density
);

  localparam int DEPTH = 6;

  logic [lbm_pkg::OMW-1:0] omega_r;
  logic [DEPTH-1:0]        vld_r;
  lbm_pkg::pop_vec_t       pop, pop_r, newp;
  lbm_pkg::q_t             ux_r, uy_r, rho_r, uxx_r, uyy_r, uxy_r;
  lbm_pkg::q_t             rho_d_r [DEPTH-1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign pop[0] = in_pop_0;  assign pop[1] = in_pop_1;  assign pop[2] = in_pop_2;
  assign pop[3] = in_pop_3;  assign pop[4] = in_pop_4;  assign pop[5] = in_pop_5;
  assign pop[6] = in_pop_6;  assign pop[7] = in_pop_7;  assign pop[8] = in_pop_8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_r <= lbm_pkg::OMEGA_RESET;
      vld_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) omega_r <= cfg_relax_rate;
      vld_r <= {vld_r[DEPTH-2:0], start && !busy};
    end
  end

  lbm_front u_front (
    .clk(clk), .pop(pop), .ux(in_vel_x), .uy(in_vel_y),
    .pop_r(pop_r), .ux_r(ux_r), .uy_r(uy_r), .rho_r(rho_r),
    .uxx_r(uxx_r), .uyy_r(uyy_r), .uxy_r(uxy_r)
  );

  for (genvar k = 0; k < lbm_pkg::NDIR; k++) begin : g_lane
    lbm_lane #(.DIR(k)) u_lane (
      .clk(clk), .omega(omega_r), .f_in(pop_r[k]), .ux_in(ux_r), .uy_in(uy_r),
      .uxx_in(uxx_r), .uyy_in(uyy_r), .uxy_in(uxy_r), .rho_in(rho_r),
      .new_pop(newp[k])
    );
  end

  // hold density alongside the lanes
  always_ff @(posedge clk) begin
    rho_d_r[0] <= rho_r;
    for (int i = 1; i < DEPTH - 1; i++) rho_d_r[i] <= rho_d_r[i-1];
  end

  assign out_valid     = vld_r[DEPTH-1];
  assign out_new_pop_0 = newp[0];
  assign out_new_pop_1 = newp[1];
  assign out_new_pop_2 = newp[2];
  assign out_new_pop_3 = newp[3];
  assign out_new_pop_4 = newp[4];
  assign out_new_pop_5 = newp[5];
  assign out_new_pop_6 = newp[6];
  assign out_new_pop_7 = newp[7];
  assign out_new_pop_8 = newp[8];
  assign out_density   = rho_d_r[DEPTH-2];

  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##DEPTH out_valid) else $error("result lost");
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##DEPTH !out_valid) else $error("result invented");

endmodule

[bench/tb_lattice_d2q9_bgk_collision.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lattice_d2q9_bgk_collision: regression bench for the D2Q9 BGK collision
// Sends lattice nodes through the command port under several idle patterns
// and omega settings, predicts each node's relaxed populations and density
// in fixed point, and checks every strobed result field by field in order.
// ----------------------------------------------------------------------------
module tb_lattice_d2q9_bgk_collision;

  localparam int PIPE_DEPTH  = 7;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] pop [9];
    logic [31:0] vx;
    logic [31:0] vy;
  } node_t;

  typedef struct {
    logic [31:0] npop [9];
    logic [31:0] rho;
  } relaxed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_pop [9];
  logic [31:0] in_vel_x = '0, in_vel_y = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [25:0] cfg_relax_rate = '0;
  logic        out_valid;
  logic [31:0] out_pop [9];
  logic [31:0] out_density;

  logic [25:0] omega_model;
  relaxed_t    pending_q [$];
  int          fail_count = 0;
  int          result_count = 0;
  int          sent_count = 0;
  int          idle_pct = 0;
  longint      cycle_count = 0;

  initial begin
    for (int k = 0; k < 9; k++) in_pop[k] = '0;
  end

  always #4 clk = ~clk;

  lattice_d2q9_bgk_collision dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pop_0(in_pop[0]), .in_pop_1(in_pop[1]), .in_pop_2(in_pop[2]),
    .in_pop_3(in_pop[3]), .in_pop_4(in_pop[4]), .in_pop_5(in_pop[5]),
    .in_pop_6(in_pop[6]), .in_pop_7(in_pop[7]), .in_pop_8(in_pop[8]),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_relax_rate(cfg_relax_rate),
    .out_valid(out_valid),
    .out_new_pop_0(out_pop[0]), .out_new_pop_1(out_pop[1]), .out_new_pop_2(out_pop[2]),
    .out_new_pop_3(out_pop[3]), .out_new_pop_4(out_pop[4]), .out_new_pop_5(out_pop[5]),
    .out_new_pop_6(out_pop[6]), .out_new_pop_7(out_pop[7]), .out_new_pop_8(out_pop[8]),
    .out_density(out_density)
  );

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clip32((a * b + 64'sd8388608) >>> 24);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clip32(a + b);
  endfunction

  function automatic relaxed_t collide_node(node_t n, logic [25:0] omega);
    relaxed_t r;
    longint f [9];
    longint rho, ux, uy, uxx, uyy, uxy, om, keep, cu, br, ax, ay, feq;
    lbm_pkg::dir_t d;
    rho = 0;
    for (int k = 0; k < 9; k++) begin
      f[k] = longint'($signed(n.pop[k]));
      rho += f[k];
    end
    rho = clip32(rho);
    ux = longint'($signed(n.vx));
    uy = longint'($signed(n.vy));
    uxx = fx_mul(ux, ux);
    uyy = fx_mul(uy, uy);
    uxy = fx_mul(ux, uy);
    om = longint'(omega);
    keep = 64'sd16777216 - om;
    for (int k = 0; k < 9; k++) begin
      d = lbm_pkg::dir_of(k);
      cu = 0;
      if (d.cx > 0) cu = fx_add(cu, ux);
      if (d.cx < 0) cu = fx_add(cu, -ux);
      if (d.cy > 0) cu = fx_add(cu, uy);
      if (d.cy < 0) cu = fx_add(cu, -uy);
      ax = (d.cx != 0) ? longint'(lbm_pkg::Q_THREE) : longint'(lbm_pkg::Q_M_ONEHALF);
      ay = (d.cy != 0) ? longint'(lbm_pkg::Q_THREE) : longint'(lbm_pkg::Q_M_ONEHALF);
      br = 64'sd16777216;
      br = fx_add(br, fx_mul(longint'(lbm_pkg::Q_THREE), cu));
      br = fx_add(br, fx_mul(ax, uxx));
      br = fx_add(br, fx_mul(ay, uyy));
      br = fx_add(br, fx_mul(longint'(d.cx * d.cy) * longint'(lbm_pkg::Q_NINE), uxy));
      feq = fx_mul(fx_mul(longint'(lbm_pkg::weight_of(k)), rho), br);
      r.npop[k] = 32'(fx_add(fx_mul(f[k], keep), fx_mul(om, feq)));
    end
    r.rho = 32'(rho);
    return r;
  endfunction

  always @(posedge clk) begin
    relaxed_t e;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lattice_d2q9_bgk_collision regression: fail");
      $finish;
    end
    if (rst_n && start && !busy) begin
      pending_q.insert(pending_q.size(), collide_node(
        '{pop: in_pop, vx: in_vel_x, vy: in_vel_y}, omega_model));
    end
    if (rst_n && out_valid) begin
      result_count++;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result density=%h", $time, out_density);
        fail_count++;
      end else begin
        e = pending_q.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (out_pop[k] !== e.npop[k]) begin
            $display("%0t new_pop_%0d expected %h actual %h", $time, k, e.npop[k], out_pop[k]);
            fail_count++;
          end
        end
        if (out_density !== e.rho) begin
          $display("%0t density expected %h actual %h", $time, e.rho, out_density);
          fail_count++;
        end
      end
    end
  end

  task automatic send_node(node_t n);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_pop <= n.pop;
    in_vel_x <= n.vx;
    in_vel_y <= n.vy;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic set_omega(logic [25:0] w);
    cfg_valid <= 1'b1;
    cfg_relax_rate <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    omega_model = w;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_q(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
      2: return 32'($urandom_range(0, 8388608));
      default: return 32'($signed($urandom_range(0, 6710886)) - 3355443);
    endcase
  endfunction

  function automatic node_t rand_node();
    node_t n;
    int pm, vm;
    pm = $urandom_range(0, 3);
    vm = $urandom_range(0, 3);
    for (int k = 0; k < 9; k++) n.pop[k] = (pm == 0) ? $urandom() : rand_q(2);
    n.vx = (vm == 0) ? rand_q(0) : rand_q(3);
    n.vy = (vm == 0) ? rand_q(0) : rand_q(3);
    return n;
  endfunction

  task automatic test_directed();
    node_t n;
    logic [31:0] pats [6] = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h0100_0000, 32'hFF00_0000};
    idle_pct = 0;
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 9; k++) n.pop[k] = pats[p];
      n.vx = pats[(p + 2) % 6];
      n.vy = pats[(p + 3) % 6];
      send_node(n);
    end
    for (int k = 0; k < 9; k++) n.pop[k] = 32'h0012_3456 + k;
    n.vx = 32'h0019_999A;
    n.vy = 32'hFFF0_0000;
    send_node(n);
    n.vx = 32'hAAAA_AAAA;
    n.vy = 32'h5555_5555;
    send_node(n);
    drain_pipe();
  endtask

  task automatic test_omega_sweep();
    logic [25:0] ws [5] = '{26'd0, 26'd33554432, 26'h3FF_FFFF, 26'd8388608, 26'd16777216};
    for (int i = 0; i < 5; i++) begin
      set_omega(ws[i]);
      idle_pct = 0;
      for (int j = 0; j < 6; j++) send_node(rand_node());
      drain_pipe();
    end
  endtask

  task automatic test_random_phases();
    int pcts [4] = '{0, 58, 0, 34};
    for (int ph = 0; ph < 4; ph++) begin
      set_omega((ph == 1) ? 26'($urandom()) : 26'($urandom_range(0, 33554432)));
      idle_pct = pcts[ph];
      for (int j = 0; j < 280; j++) send_node(rand_node());
      drain_pipe();
    end
  endtask

  initial begin
    omega_model = lbm_pkg::OMEGA_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_omega_sweep();
    test_random_phases();
    $display("sent %0d nodes, checked %0d results over several omega settings",
             sent_count, result_count);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("lattice_d2q9_bgk_collision regression: pass");
    end else begin
      $display("lattice_d2q9_bgk_collision regression: fail");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/lbm_pkg.sv
rtl/core/lbm_lane.sv
rtl/core/lbm_front.sv
rtl/core/lattice_d2q9_bgk_collision.sv
bench/tb_lattice_d2q9_bgk_collision.sv
